FILE: rtl/srld_pkg.sv
// Shared constants, types and helpers for the serial receive line discipline FIFO.
`default_nettype none
package srld_pkg;

   localparam int RING_DEPTH = 256;
   localparam int RING_AW    = $clog2(RING_DEPTH);
   localparam int FILL_W     = (RING_AW > 8) ? RING_AW : 8;
   localparam int CSR_AW     = 5;

   localparam logic [7:0] CH_XOFF = 8'h13;
   localparam logic [7:0] CH_XON  = 8'h11;
   localparam logic [7:0] CH_EOT  = 8'h04;
   localparam logic [7:0] CH_SOH  = 8'h01;
   localparam logic [7:0] CH_ESC  = 8'h1b;

   localparam logic [1:0] LINE_COOKED      = 2'd0;
   localparam logic [1:0] LINE_RAW         = 2'd1;
   localparam logic [1:0] LINE_REAL_RAW    = 2'd2;
   localparam logic [1:0] LINE_RESERVED    = 2'd3;
   localparam int         LINE_REAL_RAW_BIT = 1;

   localparam logic [7:0] INTR_FIRST_RESET = 8'h03;

   typedef enum logic [2:0] {
      REG_LINE_MODE   = 3'd0,
      REG_XOFF_BYPASS = 3'd1,
      REG_INTR_FIRST  = 3'd2,
      REG_INTR_SECOND = 3'd3,
      REG_DEBUG_EN    = 3'd4
   } reg_index_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_READ = 1'b1
   } state_type;

   typedef struct packed {
      logic       push;
      logic       pop;
      logic [7:0] wr_byte;
   } ring_cmd_type;

   typedef struct packed {
      logic               empty;
      logic               full;
      logic [RING_AW-1:0] fill;
   } ring_stat_type;

   function automatic logic [RING_AW-1:0] next_slot(input logic [RING_AW-1:0] i);
      return (i == RING_AW'(RING_DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

   // Fill level as reported: clamp at 255 for deep rings
   function automatic logic [7:0] fill_sat(input logic [RING_AW-1:0] f);
      logic [FILL_W-1:0] w;
      w = FILL_W'(f);
      if (w > FILL_W'(255)) return 8'hff;
      return w[7:0];
   endfunction

endpackage
`default_nettype wire

FILE: rtl/serial_rx_line_discipline_fifo_top.sv
// Top level: line discipline decode, configuration registers and result register.
// A receive gives its result (rsp_strobe) in the cycle after start is taken, and so
// does a read of an empty ring; a read of a non-empty ring goes through the ring's
// registered read port and then the result register. One receive per cycle while not
// busy; busy holds off a new request while a read waits on the ring memory.
// Reset clears the indexes, fill count, stop flag and configuration; ring contents stay.
`default_nettype none
module serial_rx_line_discipline_fifo_top
   import srld_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic              req_op,
   input  wire logic [7:0]        req_rx_byte,
   output logic                   rsp_strobe,
   output logic [7:0]             rsp_read_byte,
   output logic                   rsp_read_valid,
   output logic                   rsp_underflow,
   output logic [7:0]             rsp_fill_count,
   output logic                   rsp_stopped,
   output logic                   rsp_interrupt_signal,
   output logic                   rsp_hangup_signal,
   output logic                   rsp_interactive_request,
   output logic                   rsp_debug_ring,
   output logic                   rsp_accepted,
   output logic                   rsp_dropped,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [CSR_AW-1:0] paddr,
   input  wire logic [31:0]       pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   // configuration
   logic [1:0] line_mode_ff;
   logic       xoff_bypass_ff;
   logic [7:0] intr_first_ff;
   logic [7:0] intr_second_ff;
   logic       debug_en_ff;
   logic       csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_mode_ff   <= LINE_COOKED;
         xoff_bypass_ff <= 1'b0;
         intr_first_ff  <= INTR_FIRST_RESET;
         intr_second_ff <= 8'h00;
         debug_en_ff    <= 1'b0;
      end else if (csr_wr) begin
         case (paddr[CSR_AW-1:2])
            REG_LINE_MODE:   line_mode_ff   <= pwdata[1:0];
            REG_XOFF_BYPASS: xoff_bypass_ff <= pwdata[0];
            REG_INTR_FIRST:  intr_first_ff  <= pwdata[7:0];
            REG_INTR_SECOND: intr_second_ff <= pwdata[7:0];
            REG_DEBUG_EN:    debug_en_ff    <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[CSR_AW-1:2])
         REG_LINE_MODE:   prdata = {30'd0, line_mode_ff};
         REG_XOFF_BYPASS: prdata = {31'd0, xoff_bypass_ff};
         REG_INTR_FIRST:  prdata = {24'd0, intr_first_ff};
         REG_INTR_SECOND: prdata = {24'd0, intr_second_ff};
         REG_DEBUG_EN:    prdata = {31'd0, debug_en_ff};
         default:         prdata = 32'd0;
      endcase
   end

   // ring
   ring_cmd_type  ring_cmd;
   ring_stat_type ring_stat;
   logic [7:0]    ring_rd_data;

   srld_ring u_ring (
      .clock   (clock),
      .reset   (reset),
      .cmd     (ring_cmd),
      .stat    (ring_stat),
      .rd_data (ring_rd_data)
   );

   // control and result
   state_type  state_ff, state_in;
   logic       stopped_ff, stopped_in;
   logic       strobe_ff, strobe_in;
   logic [7:0] rbyte_ff, rbyte_in;
   logic       rvalid_ff, rvalid_in;
   logic       under_ff, under_in;
   logic [7:0] fill_ff, fill_in;
   logic       intr_ff, intr_in;
   logic       hup_ff, hup_in;
   logic       inter_ff, inter_in;
   logic       dring_ff, dring_in;
   logic       acc_ff, acc_in;
   logic       drop_ff, drop_in;

   logic take;
   logic store;
   logic is_intr;

   assign busy = (state_ff == ST_READ);
   assign take = start && !busy;
   assign is_intr = (intr_first_ff != 8'h00) &&
                    ((req_rx_byte == intr_first_ff) ||
                     ((intr_second_ff != 8'h00) && (req_rx_byte == intr_second_ff)));

   always_comb begin
      state_in   = state_ff;
      stopped_in = stopped_ff;
      strobe_in  = 1'b0;
      rbyte_in   = 8'h00;
      rvalid_in  = 1'b0;
      under_in   = 1'b0;
      fill_in    = fill_sat(ring_stat.fill);
      intr_in    = 1'b0;
      hup_in     = 1'b0;
      inter_in   = 1'b0;
      dring_in   = 1'b0;
      acc_in     = 1'b0;
      drop_in    = 1'b0;
      store      = 1'b0;
      ring_cmd   = '0;
      ring_cmd.wr_byte = req_rx_byte;

      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               if (req_op) begin
                  if (ring_stat.empty) begin
                     strobe_in = 1'b1;
                     under_in  = 1'b1;
                  end else begin
                     // data shows up next cycle; finish the transaction then
                     ring_cmd.pop = 1'b1;
                     state_in     = ST_READ;
                  end
               end else begin
                  strobe_in = 1'b1;
                  store     = 1'b1;
                  if (!line_mode_ff[LINE_REAL_RAW_BIT]) begin
                     if (req_rx_byte == CH_XOFF) begin
                        if (!xoff_bypass_ff) stopped_in = 1'b1;
                        store = 1'b0;
                     end else begin
                        stopped_in = 1'b0;
                        if (req_rx_byte == CH_XON) begin
                           store = 1'b0;
                        end else if (is_intr) begin
                           intr_in = 1'b1;
                           hup_in  = (req_rx_byte == CH_ESC);
                           store   = 1'b0;
                        end else if (req_rx_byte != 8'h00 && line_mode_ff == LINE_COOKED) begin
                           inter_in = (req_rx_byte == CH_EOT);
                           if (req_rx_byte == CH_SOH && debug_en_ff) begin
                              dring_in = 1'b1;
                              store    = 1'b0;
                           end
                        end
                     end
                  end
                  ring_cmd.push = store && !ring_stat.full;
                  acc_in  = store && !ring_stat.full;
                  drop_in = store && ring_stat.full;
                  fill_in = fill_sat(ring_stat.fill + RING_AW'(acc_in));
               end
            end
         end
         ST_READ: begin
            strobe_in = 1'b1;
            rvalid_in = 1'b1;
            rbyte_in  = ring_rd_data;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         stopped_ff <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         stopped_ff <= stopped_in;
         strobe_ff  <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rbyte_ff  <= rbyte_in;
      rvalid_ff <= rvalid_in;
      under_ff  <= under_in;
      fill_ff   <= fill_in;
      intr_ff   <= intr_in;
      hup_ff    <= hup_in;
      inter_ff  <= inter_in;
      dring_ff  <= dring_in;
      acc_ff    <= acc_in;
      drop_ff   <= drop_in;
   end

   assign rsp_strobe              = strobe_ff;
   assign rsp_read_byte           = rbyte_ff;
   assign rsp_read_valid          = rvalid_ff;
   assign rsp_underflow           = under_ff;
   assign rsp_fill_count          = fill_ff;
   assign rsp_stopped             = stopped_ff;
   assign rsp_interrupt_signal    = intr_ff;
   assign rsp_hangup_signal       = hup_ff;
   assign rsp_interactive_request = inter_ff;
   assign rsp_debug_ring          = dring_ff;
   assign rsp_accepted            = acc_ff;
   assign rsp_dropped             = drop_ff;

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      ring_cmd.pop |-> !ring_stat.empty)
      else $error("ring pop issued while empty");

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      ring_cmd.push |-> !ring_stat.full)
      else $error("ring push issued while full");

   a_read_result: assert property (@(posedge clock) disable iff (reset)
      (take && req_op && !ring_stat.empty) |=> ##1 (rsp_strobe && rsp_read_valid))
      else $error("read transaction result missing");

   a_busy_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("busy held longer than one cycle");

   a_acc_drop_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_accepted && rsp_dropped))
      else $error("result both accepted and dropped");

endmodule
`default_nettype wire

FILE: rtl/srld_ring.sv
// Ring buffer storage with write/read indexes, fill count and registered read port.
`default_nettype none
module srld_ring
   import srld_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire ring_cmd_type  cmd,
   output ring_stat_type      stat,
   output logic [7:0]         rd_data
);

   logic [7:0]         ring_mem_ff [RING_DEPTH];
   logic [7:0]         rd_data_ff;
   logic [RING_AW-1:0] wr_idx_ff, wr_idx_in;
   logic [RING_AW-1:0] rd_idx_ff, rd_idx_in;
   logic [RING_AW-1:0] fill_ff, fill_in;

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         ring_mem_ff[wr_idx_ff] <= cmd.wr_byte;
      end
      if (cmd.pop) begin
         rd_data_ff <= ring_mem_ff[rd_idx_ff];
      end
   end

   always_comb begin
      wr_idx_in = cmd.push ? next_slot(wr_idx_ff) : wr_idx_ff;
      rd_idx_in = cmd.pop ? next_slot(rd_idx_ff) : rd_idx_ff;
      fill_in   = fill_ff;
      if (cmd.push && !cmd.pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (cmd.pop && !cmd.push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         fill_ff   <= fill_in;
      end
   end

   assign stat.empty = (fill_ff == '0);
   assign stat.full  = (fill_ff == RING_AW'(RING_DEPTH - 1));
   assign stat.fill  = fill_ff;
   assign rd_data    = rd_data_ff;

endmodule
`default_nettype wire
